// ----- rtl/wrae_pkg.sv -----
// ----------------------------------------------------------------------------
// wrae_pkg
// shared types and constants of the weather record ascii encoder
// ----------------------------------------------------------------------------
package wrae_pkg;

	// request kinds
	localparam logic REQ_STAMP  = 1'b0;
	localparam logic REQ_UPDATE = 1'b1;

	// status codes of a result beat
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_NO_STAMP = 2'd2
	} status_t;

	// one input beat
	typedef struct packed {
		logic               req_type;
		logic [30:0]        epoch_seconds;
		logic signed [7:0]  temperature;
		logic signed [7:0]  humidity_pct;
		logic signed [11:0] pressure_hpa;
		logic [4:0]         condition_class;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
		status_t    status;
	} rec_t;

	// record geometry
	localparam int unsigned REC_CHARS = 8;
	localparam int unsigned IDX_W     = $clog2(REC_CHARS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REC_CHARS - 1);

	// countdown value is below 10^8, fits 27 bits
	localparam int unsigned COUNT_W       = 27;
	localparam int unsigned REM_W         = 24;
	localparam int unsigned DIGIT_WEIGHT  = 10_000_000;

	// decoded work for the serializer
	typedef struct packed {
		logic                      single;
		status_t                   status;
		logic                      stamp;
		logic                      set_stamp;
		logic [REC_CHARS-1:0][7:0] chars;
		logic [COUNT_W-1:0]        count;
	} job_t;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_PLUS  = 8'h2B;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] LETTER_BASE = 8'd65;

endpackage

// ----- rtl/wrae_decode.sv -----
// ----------------------------------------------------------------------------
// wrae_decode
// range checks and character formation for one input beat
// ----------------------------------------------------------------------------
module wrae_decode (
	input  wrae_pkg::item_t item,
	input  logic            stamp_loaded,
	output wrae_pkg::job_t  job
);

	localparam logic [30:0]        STAMP_MIN_EXCL = 31'd1347483647;
	localparam logic [30:0]        EPOCH_END      = 31'h7FFF_FFFF;
	localparam logic signed [7:0]  TEMP_MAX       = 8'sd99;
	localparam logic signed [7:0]  TEMP_MIN       = -8'sd99;
	localparam logic signed [7:0]  HUM_MAX        = 8'sd100;
	localparam logic [6:0]         HUM_CAP        = 7'd99;
	localparam logic signed [11:0] PRES_MAX       = 12'sd2000;
	localparam logic signed [11:0] PRES_BASE      = 12'sd850;
	localparam logic signed [11:0] PRES_SPAN_S    = 12'sd999;
	localparam logic [9:0]         PRES_SPAN      = 10'd999;
	localparam logic [4:0]         CLASS_MAX      = 5'd15;

	// tens digit of a value below 100 by reciprocal multiply
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] prod;
		prod = {8'd0, v} * 15'd205;
		return prod[14:11];
	endfunction

	function automatic logic [3:0] units_of(input logic [6:0] v, input logic [3:0] t);
		logic [6:0] sub;
		sub = v - ({3'd0, t} * 7'd10);
		return sub[3:0];
	endfunction

	function automatic logic [7:0] to_ascii(input logic [3:0] d);
		return wrae_pkg::ASCII_ZERO + {4'd0, d};
	endfunction

	logic               stamp_ok;
	logic               upd_ok;
	logic [30:0]        t_inv;
	logic signed [7:0]  temp_neg;
	logic [6:0]         mag;
	logic [3:0]         mag_t;
	logic [6:0]         hum_c;
	logic signed [11:0] p_diff;
	logic [9:0]         p_cl;
	logic [15:0]        p_prod;
	logic [3:0]         p_h;
	logic [6:0]         p_rem;
	logic [3:0]         p_t;

	always_comb begin
		stamp_ok = (item.epoch_seconds > STAMP_MIN_EXCL) && (item.epoch_seconds < EPOCH_END);
		upd_ok   = !(item.temperature > TEMP_MAX || item.temperature < TEMP_MIN ||
			item.humidity_pct < 8'sd0 || item.humidity_pct > HUM_MAX ||
			item.pressure_hpa < 12'sd0 || item.pressure_hpa > PRES_MAX ||
			item.condition_class > CLASS_MAX);

		// all-ones minus t is the inverse of t
		t_inv = ~item.epoch_seconds;

		temp_neg = -item.temperature;
		mag      = item.temperature[7] ? temp_neg[6:0] : item.temperature[6:0];
		mag_t    = tens_of(mag);

		hum_c = (item.humidity_pct == HUM_MAX) ? HUM_CAP : item.humidity_pct[6:0];

		p_diff = item.pressure_hpa - PRES_BASE;
		if (p_diff < 12'sd0) begin
			p_cl = 10'd0;
		end else if (p_diff > PRES_SPAN_S) begin
			p_cl = PRES_SPAN;
		end else begin
			p_cl = p_diff[9:0];
		end
		// hundreds digit of a value below 1000
		p_prod = {6'd0, p_cl} * 16'd41;
		p_h    = p_prod[15:12];
		p_rem  = 7'(p_cl - ({6'd0, p_h} * 10'd100));
		p_t    = tens_of(p_rem);

		job           = '0;
		job.status    = wrae_pkg::ST_OK;
		job.count     = t_inv[29:3];
		job.chars[0]  = (item.temperature > 8'sd0) ? wrae_pkg::ASCII_PLUS
			: wrae_pkg::ASCII_MINUS;
		job.chars[1]  = to_ascii(mag_t);
		job.chars[2]  = to_ascii(units_of(mag, mag_t));
		job.chars[3]  = to_ascii(tens_of(hum_c));
		job.chars[4]  = to_ascii(p_h);
		job.chars[5]  = to_ascii(p_t);
		job.chars[6]  = to_ascii(units_of(p_rem, p_t));
		job.chars[7]  = wrae_pkg::LETTER_BASE + {3'd0, item.condition_class};

		if (item.req_type == wrae_pkg::REQ_STAMP) begin
			if (stamp_ok) begin
				job.stamp     = 1'b1;
				job.set_stamp = 1'b1;
			end else begin
				job.single = 1'b1;
				job.status = wrae_pkg::ST_RANGE;
			end
		end else if (!upd_ok) begin
			job.single = 1'b1;
			job.status = wrae_pkg::ST_RANGE;
		end else if (!stamp_loaded) begin
			job.single = 1'b1;
			job.status = wrae_pkg::ST_NO_STAMP;
		end
	end

endmodule

// ----- rtl/wrae_digit.sv -----
// ----------------------------------------------------------------------------
// wrae_digit
// leading decimal digit of a value below 10^8 and its remainder
// ----------------------------------------------------------------------------
module wrae_digit (
	input  logic [wrae_pkg::COUNT_W-1:0] value,
	output logic [3:0]                   digit,
	output logic [wrae_pkg::REM_W-1:0]   rem
);

	logic [wrae_pkg::COUNT_W-1:0] base;

	always_comb begin
		digit = 4'd0;
		// independent compares against the nine multiples of the weight
		for (int unsigned k = 1; k <= 9; k++) begin
			if (value >= wrae_pkg::COUNT_W'(k * wrae_pkg::DIGIT_WEIGHT)) begin
				digit = digit + 4'd1;
			end
		end
		base = {23'd0, digit} * wrae_pkg::COUNT_W'(wrae_pkg::DIGIT_WEIGHT);
		rem  = wrae_pkg::REM_W'(value - base);
	end

endmodule

// ----- rtl/wrae_emit.sv -----
// ----------------------------------------------------------------------------
// wrae_emit
// serializes one decoded job into result beats behind an output register
// ----------------------------------------------------------------------------
module wrae_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  wrae_pkg::job_t      job,
	output logic                take,
	output logic                rec_valid,
	input  logic                rec_stall,
	output wrae_pkg::rec_t      rec
);

	logic                              busy_q;
	wrae_pkg::job_t                    job_q;
	logic [wrae_pkg::IDX_W-1:0]        idx_q;
	logic [wrae_pkg::COUNT_W-1:0]      count_q;
	logic                              rec_valid_q;
	wrae_pkg::rec_t                    rec_q;

	logic [wrae_pkg::COUNT_W-1:0]      value;
	logic [3:0]                        digit;
	logic [wrae_pkg::REM_W-1:0]        rem;
	wrae_pkg::rec_t                    cur;
	logic                              adv;

	// first digit straight from the count, later ones from remainder times ten
	assign value = (idx_q == '0) ? count_q : ((count_q << 3) + (count_q << 1));

	wrae_digit u_digit (
		.value (value),
		.digit (digit),
		.rem   (rem)
	);

	always_comb begin
		if (job_q.single) begin
			cur.char_byte = 8'h00;
			cur.last_char = 1'b1;
			cur.status    = job_q.status;
		end else if (job_q.stamp) begin
			cur.char_byte = wrae_pkg::ASCII_ZERO + {4'd0, digit};
			cur.last_char = (idx_q == wrae_pkg::LAST_IDX);
			cur.status    = wrae_pkg::ST_OK;
		end else begin
			cur.char_byte = job_q.chars[idx_q];
			cur.last_char = (idx_q == wrae_pkg::LAST_IDX);
			cur.status    = wrae_pkg::ST_OK;
		end
	end

	assign adv  = busy_q && (!rec_valid_q || !rec_stall);
	assign take = !busy_q || (adv && cur.last_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			rec_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				rec_valid_q <= 1'b1;
			end else if (!rec_stall) begin
				rec_valid_q <= 1'b0;
			end
			// a new job starts at index zero, also right after a last beat
			if (job_valid && take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv) begin
				if (cur.last_char) begin
					busy_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_q <= cur;
		end
		if (job_valid && take) begin
			job_q   <= job;
			count_q <= job.count;
		end else if (adv) begin
			count_q <= {3'd0, rem};
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

	// a status beat always closes its item and carries no character
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q && rec_q.status != wrae_pkg::ST_OK |->
			rec_q.last_char && rec_q.char_byte == 8'h00)
		else $error("status beat without last_char or with a character");

	// position counter rests at zero while idle
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> idx_q == '0)
		else $error("character index not cleared while idle");

	// a stalled output freezes the serializer
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && rec_valid_q && rec_stall |=> $stable(idx_q) && busy_q)
		else $error("serializer advanced under stall");

	// after the leading digit the remainder stays below one digit weight
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && job_q.stamp && !job_q.single && idx_q != '0 |->
			count_q < wrae_pkg::COUNT_W'(wrae_pkg::DIGIT_WEIGHT))
		else $error("digit remainder out of range");

endmodule

// ----- rtl/weather_record_ascii_encoder_top.sv -----
// ----------------------------------------------------------------------------
// weather_record_ascii_encoder_top
// compact ascii forecast record encoder, one character per output beat
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid / item_stall / item): a timestamp beat or a
//   weather update beat. a timestamp yields eight countdown digits, an update
//   yields sign, temperature, humidity tens, pressure offset and class letter.
//   rejected beats, and updates before any good timestamp, yield one status
//   beat with char_byte 0.
//   rec channel (rec_valid / rec_stall / rec): one character per beat,
//   last_char set on the final beat of each input item.
// timing
//   the first beat passes the input register, then the serializer loads the
//   decoded job and fills the output register. a record then streams one
//   beat per cycle while rec_stall is low, so a full item occupies the
//   serializer for eight beats and a status item for one; the output
//   register is the limit. the next item waits in the input register and is
//   loaded in the same cycle the previous item's last beat is produced.
// reset
//   clears all valid flags and the loaded-timestamp flag; no clearing pass.
// stall
//   a stalled beat holds in the output register, the serializer freezes, and
//   item_stall rises once the input register is also occupied.
// ----------------------------------------------------------------------------
module weather_record_ascii_encoder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  wrae_pkg::item_t   item,
	output logic              rec_valid,
	input  logic              rec_stall,
	output wrae_pkg::rec_t    rec
);

	// input register stage
	logic              s1_valid_q;
	wrae_pkg::item_t   item_s1;

	// set by the first timestamp that passes its range check
	logic              stamp_loaded_q;

	wrae_pkg::job_t    job;
	logic              emit_take;
	logic              move;

	// the input register frees up whenever the serializer takes its job
	assign item_stall = s1_valid_q && !emit_take;
	assign move       = s1_valid_q && emit_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			stamp_loaded_q <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				s1_valid_q <= 1'b1;
			end else if (move) begin
				s1_valid_q <= 1'b0;
			end
			// flag follows item order since decode happens at the hand-over
			if (move && job.set_stamp) begin
				stamp_loaded_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// checks and character formation between input register and serializer
	wrae_decode u_decode (
		.item         (item_s1),
		.stamp_loaded (stamp_loaded_q),
		.job          (job)
	);

	// serializer with the output register
	wrae_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (s1_valid_q),
		.job       (job),
		.take      (emit_take),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec       (rec)
	);

endmodule
